// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl of the worker load table selector
// needs a clock named clk and an active-low reset named rst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/wlts_pkg.sv =====
// types, codes and helper functions of the worker load table selector
// no dependencies
package wlts_pkg;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_UPD_ALL  = 2'd2,
        CMD_UPD_CONN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DONE
    } state_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    localparam logic [1:0] REG_CPU_THR   = 2'd0;
    localparam logic [1:0] REG_QUEUE_THR = 2'd1;
    localparam logic [1:0] REG_CONN_THR  = 2'd2;

    localparam logic [6:0]  CPU_LIMIT         = 7'd100;
    localparam logic [6:0]  RESET_CPU_THR     = 7'd80;
    localparam logic [15:0] RESET_QUEUE_THR   = 16'd1000;
    localparam logic [19:0] RESET_CONN_THR    = 20'd10000;
    localparam int          MIN_FOR_REBALANCE = 2;

    typedef struct packed {
        logic [7:0]  id;
        logic [6:0]  cpu;
        logic [19:0] conn;
        logic [15:0] queue;
    } entry_t;

    // write strobes and payload broadcast to every cell
    typedef struct packed {
        logic        add_en;
        logic        rem_en;
        logic        upd_all_en;
        logic        upd_conn_en;
        logic [7:0]  id;
        logic [6:0]  cpu;
        logic [19:0] conn;
        logic [15:0] queue;
    } cell_ctl_t;

    // partial selection result carried through the compare tree
    typedef struct packed {
        logic        valid;
        logic [7:0]  lo_id;
        logic [6:0]  lo_cpu;
        logic [19:0] lo_conn;
        logic [7:0]  hi_id;
        logic [6:0]  hi_cpu;
        logic [19:0] hi_conn;
        logic [6:0]  mx_cpu;
        logic [15:0] mx_queue;
        logic [19:0] mx_conn;
    } sel_t;

    function automatic sel_t make_leaf(entry_t e, logic v);
        sel_t r;
        r.valid    = v;
        r.lo_id    = e.id;
        r.lo_cpu   = e.cpu;
        r.lo_conn  = e.conn;
        r.hi_id    = e.id;
        r.hi_cpu   = e.cpu;
        r.hi_conn  = e.conn;
        r.mx_cpu   = v ? e.cpu : 7'd0;
        r.mx_queue = v ? e.queue : 16'd0;
        r.mx_conn  = v ? e.conn : 20'd0;
        return r;
    endfunction

    // a is the earlier half of the table, so ties keep a
    function automatic sel_t sel_merge(sel_t a, sel_t b);
        sel_t r;
        r = a;
        if (!a.valid)
        begin
            r = b;
        end
        else if (b.valid)
        begin
            if (b.lo_cpu < a.lo_cpu || (b.lo_cpu == a.lo_cpu && b.lo_conn < a.lo_conn))
            begin
                r.lo_id   = b.lo_id;
                r.lo_cpu  = b.lo_cpu;
                r.lo_conn = b.lo_conn;
            end
            if (b.hi_cpu > a.hi_cpu || (b.hi_cpu == a.hi_cpu && b.hi_conn > a.hi_conn))
            begin
                r.hi_id   = b.hi_id;
                r.hi_cpu  = b.hi_cpu;
                r.hi_conn = b.hi_conn;
            end
            r.mx_cpu   = (b.mx_cpu > a.mx_cpu) ? b.mx_cpu : a.mx_cpu;
            r.mx_queue = (b.mx_queue > a.mx_queue) ? b.mx_queue : a.mx_queue;
            r.mx_conn  = (b.mx_conn > a.mx_conn) ? b.mx_conn : a.mx_conn;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/wlts_if.sv =====
// channel interfaces of the worker load table selector: command, result, config write
// no dependencies
interface wlts_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  worker_id;
    logic [6:0]  cpu_load;
    logic [19:0] connections;
    logic [15:0] queue_depth;

    modport source (output valid, command, worker_id, cpu_load, connections, queue_depth,
                    input ready);
    modport sink   (input valid, command, worker_id, cpu_load, connections, queue_depth,
                    output ready);
endinterface

interface wlts_rsp_if #(parameter int COUNT_W = 5);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               table_nonempty;
    logic [7:0]         least_loaded_id;
    logic [7:0]         most_loaded_id;
    logic               rebalance_needed;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, status, table_nonempty, least_loaded_id, most_loaded_id,
                    rebalance_needed, entry_count, input ready);
    modport sink   (input valid, status, table_nonempty, least_loaded_id, most_loaded_id,
                    rebalance_needed, entry_count, output ready);
endinterface

interface wlts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wlts_cell.sv =====
// one table slot of the worker load table selector chain
// depends on wlts_pkg
module wlts_cell import wlts_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic          clk,
    input  logic [CW-1:0] count,
    input  cell_ctl_t     ctl,
    input  logic          found_in,
    output logic          found_out,
    input  entry_t        nbr,
    output entry_t        ent,
    output sel_t          leaf
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid;
    logic   match;
    logic   first;

    assign valid     = count > CW'(IDX);
    assign match     = valid && (ent_reg.id == ctl.id);
    assign found_out = found_in | match;
    assign first     = match & ~found_in;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.add_en && count == CW'(IDX))
        begin
            ent_next.id    = ctl.id;
            ent_next.cpu   = '0;
            ent_next.conn  = '0;
            ent_next.queue = '0;
        end
        else if (ctl.rem_en && found_out)
        begin
            // close the gap: take the neighbor's entry
            ent_next = nbr;
        end
        else if (ctl.upd_all_en && first)
        begin
            ent_next.cpu   = ctl.cpu;
            ent_next.conn  = ctl.conn;
            ent_next.queue = ctl.queue;
        end
        else if (ctl.upd_conn_en && first)
        begin
            ent_next.conn = ctl.conn;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent  = ent_reg;
    assign leaf = make_leaf(ent_reg, valid);

endmodule

// ===== rtl/core/wlts_tree.sv =====
// registered binary compare tree, each level registered, heap-ordered nodes
// depends on wlts_pkg
module wlts_tree import wlts_pkg::*; #(
    parameter int N      = 16,
    parameter int LEVELS = 4
) (
    input  logic clk,
    input  sel_t leaves [N],
    output sel_t root
);

    localparam int P = 1 << LEVELS;

    sel_t leaf_s   [P];
    sel_t node_reg [1:P-1];

    genvar i;
    generate
        for (i = 0; i < P; i++)
        begin : g_leaf
            if (i < N)
            begin : g_real
                assign leaf_s[i] = leaves[i];
            end
            else
            begin : g_pad
                assign leaf_s[i] = '0;
            end
        end

        for (i = 1; i < P; i++)
        begin : g_node
            if (2 * i >= P)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= sel_merge(leaf_s[2 * i - P], leaf_s[2 * i + 1 - P]);
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= sel_merge(node_reg[2 * i], node_reg[2 * i + 1]);
                end
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

// ===== rtl/core/worker_load_table_selector_core.sv =====
// worker load table selector: chain of table cells, compare tree, control and result register
// depends on wlts_pkg, wlts_if, wlts_cell, wlts_tree and assert_macros.svh
//
// usage
//   req carries one command item: add, remove, update all loads, update connections only
//   rsp carries one result item per command: status, least and most loaded id,
//   rebalance flag and entry count after the command
//   cfg writes the cpu, queue and connection thresholds; always ready, write only when idle
// timing
//   the command is applied to the cell chain at the edge it is accepted
//   the compare tree then reduces the table level by level, each level registered,
//   and the sequencer loads its root into the result register once it reaches done;
//   one item in flight
// reset
//   table empty, thresholds at 80 / 1000 / 10000, no result pending
// stall
//   a result held in the output register waits for rsp.ready; req.ready returns once
//   the result is loaded, so a finished result waits in the tree until the register frees
`include "assert_macros.svh"

module worker_load_table_selector_core import wlts_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    wlts_req_if.sink   req,
    wlts_rsp_if.source rsp,
    wlts_cfg_if.sink   cfg
);

    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int LEVELS = $clog2(MAX_ENTRIES);
    localparam int LW     = $clog2(LEVELS + 1);

    // control
    state_t          state_reg;
    state_t          state_next;
    logic [LW-1:0]   step_reg;
    logic [LW-1:0]   step_next;
    logic            accept;
    logic            load_out;

    // table bookkeeping
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic            full;
    logic            any_found;
    cmd_t            cmd;
    logic [6:0]      cpu_sat;
    cell_ctl_t       ctl;

    // thresholds
    logic [6:0]      cpu_thr_reg;
    logic [15:0]     queue_thr_reg;
    logic [19:0]     conn_thr_reg;

    // chain wiring
    logic            found   [MAX_ENTRIES+1];
    entry_t          ent     [MAX_ENTRIES];
    entry_t          nbr     [MAX_ENTRIES];
    sel_t            leaves  [MAX_ENTRIES];
    sel_t            root;

    // result register
    logic            out_valid_reg;
    logic [1:0]      out_status_reg;
    logic            out_nonempty_reg;
    logic [7:0]      out_least_reg;
    logic [7:0]      out_most_reg;
    logic            out_rebal_reg;
    logic [CW-1:0]   out_count_reg;
    logic            rebal;

    assign accept  = req.valid && req.ready;
    assign cmd     = cmd_t'(req.command);
    assign full    = count_reg == CW'(MAX_ENTRIES);
    assign cpu_sat = (req.cpu_load > CPU_LIMIT) ? CPU_LIMIT : req.cpu_load;

    // broadcast strobes, qualified by the handshake
    always_comb
    begin
        ctl.add_en      = accept && cmd == CMD_ADD && !full;
        ctl.rem_en      = accept && cmd == CMD_REMOVE;
        ctl.upd_all_en  = accept && cmd == CMD_UPD_ALL;
        ctl.upd_conn_en = accept && cmd == CMD_UPD_CONN;
        ctl.id          = req.worker_id;
        ctl.cpu         = cpu_sat;
        ctl.conn        = req.connections;
        ctl.queue       = req.queue_depth;
    end

    // first-match flag ripples down the chain; each cell hands its entry to the one before
    assign found[0]  = 1'b0;
    assign any_found = found[MAX_ENTRIES];

    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            if (i + 1 < MAX_ENTRIES)
            begin : g_mid
                assign nbr[i] = ent[i+1];
            end
            else
            begin : g_last
                assign nbr[i] = '0;
            end

            wlts_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .count     (count_reg),
                .ctl       (ctl),
                .found_in  (found[i]),
                .found_out (found[i+1]),
                .nbr       (nbr[i]),
                .ent       (ent[i]),
                .leaf      (leaves[i])
            );
        end
    endgenerate

    wlts_tree #(
        .N      (MAX_ENTRIES),
        .LEVELS (LEVELS)
    ) u_tree (
        .clk    (clk),
        .leaves (leaves),
        .root   (root)
    );

    // status and count of the accepted command
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            case (cmd)
                CMD_ADD:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        count_next  = count_reg + CW'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    status_next = any_found ? STATUS_OK : STATUS_MISSING;
                    if (any_found)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = any_found ? STATUS_OK : STATUS_MISSING;
                end
            endcase
        end
    end

    // sequencer: idle, walk the tree levels, then hand over to the result register
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        req.ready  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ST_REDUCE;
                    step_next  = '0;
                end
            end
            ST_REDUCE:
            begin
                step_next = step_reg + LW'(1);
                if (step_reg == LW'(LEVELS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // threshold registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_thr_reg   <= RESET_CPU_THR;
            queue_thr_reg <= RESET_QUEUE_THR;
            conn_thr_reg  <= RESET_CONN_THR;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CPU_THR:   cpu_thr_reg   <= cfg.data[6:0];
                REG_QUEUE_THR: queue_thr_reg <= cfg.data[15:0];
                REG_CONN_THR:  conn_thr_reg  <= cfg.data;
                default:       ;
            endcase
        end
    end

    // rebalance: two or more entries and any maximum over its threshold
    assign rebal = (count_reg >= CW'(MIN_FOR_REBALANCE)) &&
                   (root.mx_cpu > cpu_thr_reg || root.mx_queue > queue_thr_reg ||
                    root.mx_conn > conn_thr_reg);

    // result register, only its valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg   <= status_reg;
            out_nonempty_reg <= count_reg != '0;
            out_least_reg    <= root.valid ? root.lo_id : 8'd0;
            out_most_reg     <= root.valid ? root.hi_id : 8'd0;
            out_rebal_reg    <= rebal;
            out_count_reg    <= count_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.table_nonempty   = out_nonempty_reg;
    assign rsp.least_loaded_id  = out_least_reg;
    assign rsp.most_loaded_id   = out_most_reg;
    assign rsp.rebalance_needed = out_rebal_reg;
    assign rsp.entry_count      = $bits(rsp.entry_count)'(out_count_reg);

    // checks
    `ASSERT_ALWAYS(a_count_bound, (!rst_n || count_reg <= CW'(MAX_ENTRIES)), "entry count above table size")
    `ASSERT_CLK(a_count_only_on_accept, (!accept |=> $stable(count_reg)), "count moved with no item")
    `ASSERT_CLK(a_result_from_done, ($rose(out_valid_reg) |-> $past(state_reg == ST_DONE)), "result loaded outside done")
    `ASSERT_CLK(a_full_means_full, (load_out && status_reg == STATUS_FULL |-> count_reg == CW'(MAX_ENTRIES)), "table full reported on a table with room")

endmodule

// ===== verif/wlts_report_checker.sv =====
// checker for the worker load table selector: watches the command, result and config channels,
// keeps its own copy of the worker table and compares every result item field by field
// depends on wlts_pkg and the channel interfaces in wlts_if
module wlts_report_checker import wlts_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    wlts_req_if  req,
    wlts_rsp_if  rsp,
    wlts_cfg_if  cfg,
    output int   report_mismatches,
    output int   reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        logic [1:0] status;
        logic       nonempty;
        logic [7:0] least_id;
        logic [7:0] most_id;
        logic       rebalance;
        logic [4:0] count;
    } load_report_t;

    entry_t       workers[$];
    load_report_t pending_reports[$];
    load_report_t want;
    logic [6:0]   cpu_thr;
    logic [15:0]  queue_thr;
    logic [19:0]  conn_thr;
    int           reports_seen;

    initial
    begin
        report_mismatches = 0;
        reports_pending   = 0;
        reports_seen      = 0;
    end

    // applies one command to the table copy and returns the report that follows it
    function automatic load_report_t apply_command(cmd_t op, logic [7:0] id, logic [6:0] cpu_in,
                                                   logic [19:0] conn, logic [15:0] depth);
        load_report_t r;
        entry_t       fresh;
        logic [6:0]   cpu;
        logic [6:0]   top_cpu;
        logic [15:0]  top_queue;
        logic [19:0]  top_conn;
        int           hit;
        int           lo;
        int           hi;
        r   = '0;
        hit = -1;
        cpu = (cpu_in > CPU_LIMIT) ? CPU_LIMIT : cpu_in;
        foreach (workers[i])
        begin
            if (hit < 0 && workers[i].id == id)
            begin
                hit = i;
            end
        end
        if (op == CMD_ADD)
        begin
            if (workers.size() >= TABLE_DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                fresh    = '0;
                fresh.id = id;
                workers.push_back(fresh);
            end
        end
        else if (hit < 0)
        begin
            r.status = STATUS_MISSING;
        end
        else if (op == CMD_REMOVE)
        begin
            workers.delete(hit);
        end
        else if (op == CMD_UPD_ALL)
        begin
            workers[hit].cpu   = cpu;
            workers[hit].conn  = conn;
            workers[hit].queue = depth;
        end
        else
        begin
            workers[hit].conn = conn;
        end

        if (workers.size() > 0)
        begin
            lo        = 0;
            hi        = 0;
            top_cpu   = '0;
            top_queue = '0;
            top_conn  = '0;
            foreach (workers[i])
            begin
                // cpu first, connections second, earlier entry keeps a tie
                if (workers[i].cpu < workers[lo].cpu ||
                    (workers[i].cpu == workers[lo].cpu && workers[i].conn < workers[lo].conn))
                begin
                    lo = i;
                end
                if (workers[i].cpu > workers[hi].cpu ||
                    (workers[i].cpu == workers[hi].cpu && workers[i].conn > workers[hi].conn))
                begin
                    hi = i;
                end
                if (workers[i].cpu > top_cpu)
                begin
                    top_cpu = workers[i].cpu;
                end
                if (workers[i].queue > top_queue)
                begin
                    top_queue = workers[i].queue;
                end
                if (workers[i].conn > top_conn)
                begin
                    top_conn = workers[i].conn;
                end
            end
            r.nonempty  = 1'b1;
            r.least_id  = workers[lo].id;
            r.most_id   = workers[hi].id;
            r.rebalance = (workers.size() >= MIN_FOR_REBALANCE) &&
                          (top_cpu > cpu_thr || top_queue > queue_thr || top_conn > conn_thr);
        end
        r.count = 5'(workers.size());
        return r;
    endfunction

    function automatic void compare_field(string field, logic [19:0] exp_val, logic [19:0] act);
        if (act !== exp_val)
        begin
            report_mismatches++;
            if (report_mismatches <= 10)
            begin
                $display("mismatch in report %0d, %s: expected %0d, got %0d",
                         reports_seen, field, exp_val, act);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            workers.delete();
            pending_reports.delete();
            cpu_thr   = RESET_CPU_THR;
            queue_thr = RESET_QUEUE_THR;
            conn_thr  = RESET_CONN_THR;
        end
        else
        begin
            // results first: a result never belongs to an item taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    report_mismatches++;
                    if (report_mismatches <= 10)
                    begin
                        $display("result item %0d arrived with no command waiting", reports_seen);
                    end
                end
                else
                begin
                    want = pending_reports.pop_front();
                    compare_field("status", want.status, rsp.status);
                    compare_field("table_nonempty", want.nonempty, rsp.table_nonempty);
                    compare_field("least_loaded_id", want.least_id, rsp.least_loaded_id);
                    compare_field("most_loaded_id", want.most_id, rsp.most_loaded_id);
                    compare_field("rebalance_needed", want.rebalance, rsp.rebalance_needed);
                    compare_field("entry_count", want.count, rsp.entry_count);
                end
                reports_seen++;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CPU_THR:   cpu_thr   = cfg.data[6:0];
                    REG_QUEUE_THR: queue_thr = cfg.data[15:0];
                    REG_CONN_THR:  conn_thr  = cfg.data;
                    default:       ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                pending_reports.push_back(apply_command(cmd_t'(req.command), req.worker_id,
                                                        req.cpu_load, req.connections,
                                                        req.queue_depth));
            end
        end
        reports_pending = pending_reports.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// top of the worker load table selector testbench: clock, reset, command and config stimulus,
// result back-pressure and the verdict
// depends on wlts_pkg, wlts_if, worker_load_table_selector_core and wlts_report_checker
module tb_top import wlts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // config index with no register behind it, writes there must change nothing
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int HOLD_CYCLES     = 300;
    // drain time covering the apply, the clog2(16) tree levels and the result register
    localparam int DRAIN_CYCLES    = 12;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_request;
    int   mismatch_total;
    int   reports_outstanding;

    wlts_req_if               req_ch ();
    wlts_rsp_if #(.COUNT_W(5)) rsp_ch ();
    wlts_cfg_if               cfg_ch ();

    worker_load_table_selector_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    wlts_report_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .cfg               (cfg_ch),
        .report_mismatches (mismatch_total),
        .reports_pending   (reports_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request so the block backs up
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // offers one command item, after a random gap, and returns at the falling edge after it
    // is taken; valid stays high so a following call goes back to back, any other step
    // has to lower it first
    task automatic issue_command(cmd_t op, logic [7:0] id, logic [6:0] cpu,
                                 logic [19:0] conn, logic [15:0] depth);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.command     = op;
        req_ch.worker_id   = id;
        req_ch.cpu_load    = cpu;
        req_ch.connections = conn;
        req_ch.queue_depth = depth;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // same pattern for a threshold write; the caller lowers valid after the last one
    task automatic write_register(logic [1:0] index, logic [19:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // stop offering items and wait until every result item has come back
    task automatic wait_table_quiet();
        req_ch.valid = 1'b0;
        while (reports_outstanding != 0) @(negedge clk);
    endtask

    initial
    begin
        int          roll;
        bit          add_heavy;
        cmd_t        op;
        logic [7:0]  id;
        logic [6:0]  cpu;
        logic [19:0] conn;
        logic [15:0] depth;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_ADD;
        req_ch.worker_id   = '0;
        req_ch.cpu_load    = '0;
        req_ch.connections = '0;
        req_ch.queue_depth = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_CPU_THR;
        cfg_ch.data        = '0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        hold_request       = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, reset thresholds, no idling
        // commands on an empty table: id not found, selections read as zero
        issue_command(CMD_REMOVE, 8'd5, 7'd0, 20'd0, 16'd0);
        issue_command(CMD_UPD_ALL, 8'd5, 7'd50, 20'd10, 16'd10);
        // extreme ids, then cpu above the limit saturates, all maxima at once
        issue_command(CMD_ADD, 8'd0, 7'd0, 20'd0, 16'd0);
        issue_command(CMD_ADD, 8'd255, 7'd127, 20'hFFFFF, 16'hFFFF);
        issue_command(CMD_UPD_ALL, 8'd255, 7'd127, 20'hFFFFF, 16'hFFFF);
        // duplicate id is accepted, updates hit only the first match
        issue_command(CMD_ADD, 8'd255, 7'd0, 20'd0, 16'd0);
        issue_command(CMD_UPD_CONN, 8'd255, 7'd0, 20'd12345, 16'd0);
        // cpu tie between two entries, connections decide
        issue_command(CMD_UPD_ALL, 8'd0, 7'd100, 20'd5, 16'd0);
        // remove the first of the duplicates, later entries shift down
        issue_command(CMD_REMOVE, 8'd255, 7'd0, 20'd0, 16'd0);
        issue_command(CMD_UPD_CONN, 8'd77, 7'd0, 20'd9, 16'd0);
        // fill the table with zero-load entries (full ties), then one add too many
        for (int i = 0; i < 15; i++)
        begin
            issue_command(CMD_ADD, 8'(i * 17 + 1), 7'd0, 20'd0, 16'd0);
        end
        issue_command(CMD_REMOVE, 8'd0, 7'd0, 20'd0, 16'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // thresholds change only with the block idle
            wait_table_quiet();
            case (phase)
                0:
                begin
                    write_register(REG_CPU_THR, 20'(RESET_CPU_THR));
                    write_register(REG_QUEUE_THR, 20'(RESET_QUEUE_THR));
                    write_register(REG_CONN_THR, RESET_CONN_THR);
                    write_register(REG_SPARE, 20'($urandom));
                end
                1:
                begin
                    // lowest thresholds: any nonzero load asks for rebalance once two or more entries are held
                    write_register(REG_CPU_THR, 20'd0);
                    write_register(REG_QUEUE_THR, 20'd0);
                    write_register(REG_CONN_THR, 20'd0);
                end
                2:
                begin
                    // highest thresholds, cpu above what saturation allows
                    write_register(REG_CPU_THR, 20'd127);
                    write_register(REG_QUEUE_THR, 20'hFFFF);
                    write_register(REG_CONN_THR, 20'hFFFFF);
                end
                3:
                begin
                    write_register(REG_CPU_THR, 20'($urandom_range(0, 100)));
                    write_register(REG_QUEUE_THR, 20'($urandom_range(0, 2000)));
                    write_register(REG_CONN_THR, 20'($urandom_range(0, 20000)));
                end
                4:
                begin
                    // full-width data, upper bits must be dropped
                    write_register(REG_CPU_THR, 20'($urandom));
                    write_register(REG_QUEUE_THR, 20'($urandom));
                    write_register(REG_CONN_THR, 20'($urandom));
                    write_register(REG_SPARE, 20'hFFFFF);
                end
                default:
                begin
                    write_register(REG_CPU_THR, 20'd100);
                    write_register(REG_QUEUE_THR, 20'd2000);
                    write_register(REG_CONN_THR, 20'd20000);
                end
            endcase
            cfg_ch.valid = 1'b0;

            // receiver slow then sender slow, then both at full rate
            if (phase < 2)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 63;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // alternate filling and draining phases so full and empty tables both recur
            add_heavy = (phase % 2 == 0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == 40)
                begin
                    hold_request = 1'b1;
                end
                if (phase == 3 && n == 100)
                begin
                    wait_table_quiet();
                end
                roll = $urandom_range(0, 99);
                if (roll < (add_heavy ? 45 : 20))
                begin
                    op = CMD_ADD;
                end
                else if (roll < 60)
                begin
                    op = CMD_REMOVE;
                end
                else if (roll < 85)
                begin
                    op = CMD_UPD_ALL;
                end
                else
                begin
                    op = CMD_UPD_CONN;
                end
                // mostly a small id pool so removes and updates find their entry
                id    = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
                cpu   = 7'($urandom_range(0, 127));
                conn  = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                    : 20'($urandom_range(0, 20000));
                depth = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2000));
                issue_command(op, id, cpu, conn, depth);
            end
        end

        wait_table_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_total == 0 && reports_outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== worker_load_table_selector_core.f =====
+incdir+rtl/core
rtl/core/wlts_pkg.sv
rtl/core/wlts_if.sv
rtl/core/wlts_cell.sv
rtl/core/wlts_tree.sv
rtl/core/worker_load_table_selector_core.sv
verif/wlts_report_checker.sv
verif/tb_top.sv
